// ===== rtl/core/wob_pkg.sv =====
// Package for the wavetable oscillator bank: types, constants, sine table.
`timescale 1ns / 1ps
package wob_pkg;

    localparam int SINE_SIZE  = 1024;
    localparam int SINE_AW    = $clog2(SINE_SIZE);
    localparam int QUARTER    = SINE_SIZE / 4;
    localparam int QT_AW      = $clog2(QUARTER + 1);
    localparam int MAX_OSC    = 255;
    localparam int OSC_AW     = $clog2(MAX_OSC + 1);
    localparam int HOP_MAX    = 1024;
    localparam int BUF_AW     = $clog2(HOP_MAX);
    localparam int HOP_W      = 11;
    localparam int CNT_W      = 11;
    localparam int PH_W       = SINE_AW + 32;
    localparam int AMP_W      = 33;
    localparam int DIV_W      = 57;
    localparam int REM_W      = HOP_W + 1;
    localparam int PIPE_DEPTH = 4;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    localparam logic CFG_HOP = 1'b0;
    localparam logic CFG_MAG = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [7:0]          osc_index;
        logic [15:0]         prev_amp;
        logic [15:0]         next_amp;
        logic [23:0]         prev_freq;
        logic [23:0]         next_freq;
        logic signed [31:0]  prior_sample;
    } t_in;

    typedef struct packed {
        logic signed [31:0]  out_sample;
        logic                last_sample;
    } t_out;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PH_RD, ST_SETUP, ST_DIVA_LD, ST_DIVA, ST_DIVB_LD,
        ST_DIVB, ST_RUN_LD, ST_RUN, ST_FLUSH, ST_DR_RD, ST_DR_WR
    } t_state;

    typedef struct packed {
        logic             clr_we;
        logic             latch;
        logic             setup;
        logic             div_ld_a;
        logic             div_ld_b;
        logic             div_step;
        logic             st_damp;
        logic             st_dinc;
        logic             smp;
        logic             ph_wr;
        logic             dr_wr;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic             skip;
        logic [HOP_W-1:0] hop;
    } t_stat;

    typedef logic [QUARTER:0][15:0] t_qtab;

    // quarter-wave table, entry m = round(32767*sin(2*pi*m/SINE_SIZE))
    function automatic t_qtab build_qtab();
        t_qtab             tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint unsigned   s;
        longint unsigned   r;
        for (int m = 0; m <= QUARTER; m++) begin
            x  = (longint'(m) * 2 * PI_Q30) / SINE_SIZE;
            x2 = (x * x) >> 30;
            t  = ONE_Q30;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            r  = (s * 32767 + (64'd1 << 29)) >> 30;
            if (r > 32767) r = 32767;
            tab[m] = r[15:0];
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    function automatic logic signed [15:0] sine_at(input logic [SINE_AW-1:0] k);
        logic [QT_AW-1:0] m;
        logic             neg;
        logic [15:0]      v;
        case (k[SINE_AW-1:SINE_AW-2])
            2'd0: begin
                m   = QT_AW'(k[SINE_AW-3:0]);
                neg = 1'b0;
            end
            2'd1: begin
                m   = QT_AW'((SINE_AW + 1)'(SINE_SIZE / 2) - (SINE_AW + 1)'(k));
                neg = 1'b0;
            end
            2'd2: begin
                m   = QT_AW'(k[SINE_AW-3:0]);
                neg = 1'b1;
            end
            default: begin
                m   = QT_AW'((SINE_AW + 1)'(SINE_SIZE) - (SINE_AW + 1)'(k));
                neg = 1'b1;
            end
        endcase
        v = QTAB[m];
        return neg ? -$signed(v) : $signed(v);
    endfunction

endpackage

// ===== rtl/core/wob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wob_ram #(
    parameter int W = 32,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/wob_ctrl.sv =====
// Sequencer for the oscillator bank: clear pass, setup, division, sample loop, drain.
`timescale 1ns / 1ps
module wob_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_cmd,
    input  wob_pkg::t_stat i_stat,
    output logic           o_busy,
    output wob_pkg::t_cmd  o_cmd
);
    wob_pkg::t_state               r_state, n_state;
    logic [wob_pkg::CNT_W-1:0]     r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wob_pkg::ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            wob_pkg::ST_CLEAR: begin
                if (r_cnt == wob_pkg::CNT_W'(wob_pkg::HOP_MAX - 1)) begin
                    n_state = wob_pkg::ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wob_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = i_cmd ? wob_pkg::ST_DR_RD : wob_pkg::ST_PH_RD;
                end
            end
            wob_pkg::ST_PH_RD: n_state = i_stat.skip ? wob_pkg::ST_IDLE : wob_pkg::ST_SETUP;
            wob_pkg::ST_SETUP: n_state = wob_pkg::ST_DIVA_LD;
            wob_pkg::ST_DIVA_LD: begin
                n_state = wob_pkg::ST_DIVA;
                n_cnt   = '0;
            end
            wob_pkg::ST_DIVA: begin
                if (r_cnt == wob_pkg::CNT_W'(wob_pkg::DIV_W - 1)) begin
                    n_state = wob_pkg::ST_DIVB_LD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wob_pkg::ST_DIVB_LD: n_state = wob_pkg::ST_DIVB;
            wob_pkg::ST_DIVB: begin
                if (r_cnt == wob_pkg::CNT_W'(wob_pkg::DIV_W - 1)) begin
                    n_state = wob_pkg::ST_RUN_LD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wob_pkg::ST_RUN_LD: begin
                n_state = wob_pkg::ST_RUN;
                n_cnt   = '0;
            end
            wob_pkg::ST_RUN: begin
                if (r_cnt == i_stat.hop - 1'b1) begin
                    n_state = wob_pkg::ST_FLUSH;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wob_pkg::ST_FLUSH: begin
                if (r_cnt == wob_pkg::CNT_W'(wob_pkg::PIPE_DEPTH - 1)) begin
                    n_state = wob_pkg::ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            wob_pkg::ST_DR_RD: n_state = wob_pkg::ST_DR_WR;
            wob_pkg::ST_DR_WR: n_state = wob_pkg::ST_IDLE;
            default: begin
                n_state = wob_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.cnt      = r_cnt;
        o_cmd.clr_we   = (r_state == wob_pkg::ST_CLEAR);
        o_cmd.latch    = (r_state == wob_pkg::ST_IDLE) && i_start;
        o_cmd.setup    = (r_state == wob_pkg::ST_SETUP);
        o_cmd.div_ld_a = (r_state == wob_pkg::ST_DIVA_LD);
        o_cmd.div_ld_b = (r_state == wob_pkg::ST_DIVB_LD);
        o_cmd.st_damp  = (r_state == wob_pkg::ST_DIVB_LD);
        o_cmd.div_step = (r_state == wob_pkg::ST_DIVA) || (r_state == wob_pkg::ST_DIVB);
        o_cmd.st_dinc  = (r_state == wob_pkg::ST_RUN_LD);
        o_cmd.smp      = (r_state == wob_pkg::ST_RUN);
        o_cmd.ph_wr    = (r_state == wob_pkg::ST_FLUSH) && (r_cnt == '0);
        o_cmd.dr_wr    = (r_state == wob_pkg::ST_DR_WR);
        o_busy         = (r_state != wob_pkg::ST_IDLE);
    end
endmodule

// ===== rtl/core/wob_dpath.sv =====
// Datapath: config registers, ramp setup divider, sample pipeline, buffers, drain.
`timescale 1ns / 1ps
module wob_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  wob_pkg::t_in   i_item,
    input  wob_pkg::t_cmd  i_cmd,
    input  logic           i_cfg_we,
    input  logic           i_cfg_addr,
    input  logic [31:0]    i_cfg_wdata,
    output wob_pkg::t_stat o_stat,
    output logic           o_strobe,
    output wob_pkg::t_out  o_result
);
    localparam int AW = wob_pkg::SINE_AW;

    logic [wob_pkg::HOP_W-1:0]  r_hop;
    logic [31:0]                r_mag;
    wob_pkg::t_in               r_in;
    logic [wob_pkg::HOP_W-1:0]  hop_eff;

    logic signed [wob_pkg::AMP_W-1:0] r_amp, r_damp;
    logic [wob_pkg::PH_W-1:0]         r_inc, r_dinc, r_phase, inc_nxt;
    logic signed [57:0]               r_pmul;
    logic [wob_pkg::DIV_W-1:0]        r_quo;
    logic [wob_pkg::REM_W-1:0]        r_rem;
    logic                             r_neg;
    logic [wob_pkg::REM_W-1:0]        rem_sh;
    logic signed [wob_pkg::DIV_W:0]   quo_s;

    logic signed [16:0] damp_diff;
    logic signed [24:0] freq_diff;
    logic [31:0]        damp_mag;

    logic [wob_pkg::MAX_OSC:0]       r_pv;
    logic [AW-1:0]                   ph_rdata;

    logic [wob_pkg::BUF_AW-1:0] r_dptr;
    logic [31:0]                buf_rdata;
    logic                       buf_we;
    logic [wob_pkg::BUF_AW-1:0] buf_waddr, buf_raddr;
    logic [31:0]                buf_wdata;

    logic                       r1_v, r2_v, r3_v, r4_v;
    logic signed [15:0]         r1_y1, r1_y2, r2_y1;
    logic [15:0]                r1_f;
    logic signed [16:0]         r1_ah, r2_ah, r3_ah, r3_y;
    logic [wob_pkg::BUF_AW-1:0] r1_a, r2_a, r3_a, r4_a;
    logic signed [33:0]         r2_d, r4_p;
    logic signed [16:0]         dy;
    logic signed [17:0]         ysum;
    logic signed [33:0]         acc, dsum;
    logic                       last;

    wob_pkg::t_out              r_out;
    logic                       r_stb;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7fffffff;
        if (v < -34'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop <= wob_pkg::HOP_W'(256);
            r_mag <= 32'd389566;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                wob_pkg::CFG_HOP: r_hop <= i_cfg_wdata[wob_pkg::HOP_W-1:0];
                wob_pkg::CFG_MAG: r_mag <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_hop == '0) begin
            hop_eff = wob_pkg::HOP_W'(1);
        end else if (r_hop > wob_pkg::HOP_W'(wob_pkg::HOP_MAX)) begin
            hop_eff = wob_pkg::HOP_W'(wob_pkg::HOP_MAX);
        end else begin
            hop_eff = r_hop;
        end
    end

    assign o_stat.hop  = hop_eff;
    assign o_stat.skip = (r_in.osc_index == '0)
                      || (int'(r_in.osc_index) > wob_pkg::MAX_OSC)
                      || ((r_in.prev_amp == '0) && (r_in.next_amp == '0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_item;
        end
    end

    assign damp_diff = $signed({1'b0, r_in.next_amp}) - $signed({1'b0, r_in.prev_amp});
    assign freq_diff = $signed({1'b0, r_in.next_freq}) - $signed({1'b0, r_in.prev_freq});
    assign damp_mag  = damp_diff[16] ? {16'(-damp_diff), 16'b0} : {damp_diff[15:0], 16'b0};
    assign rem_sh    = {r_rem[wob_pkg::REM_W-2:0], r_quo[wob_pkg::DIV_W-1]};
    assign quo_s     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign inc_nxt   = r_inc + r_dinc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_amp   <= wob_pkg::AMP_W'({1'b0, r_in.prev_amp, 16'b0});
            r_inc   <= wob_pkg::PH_W'(r_mag * r_in.prev_freq);
            r_pmul  <= $signed({1'b0, r_mag}) * freq_diff;
            r_phase <= {(r_pv[r_in.osc_index] ? ph_rdata : AW'(0)), 32'b0};
        end else if (i_cmd.smp) begin
            r_amp   <= r_amp + r_damp;
            r_inc   <= inc_nxt;
            r_phase <= r_phase + inc_nxt;
        end
        if (i_cmd.div_ld_a) begin
            r_quo <= wob_pkg::DIV_W'(damp_mag);
            r_neg <= damp_diff[16];
            r_rem <= '0;
        end else if (i_cmd.div_ld_b) begin
            r_quo <= r_pmul[57] ? wob_pkg::DIV_W'(-r_pmul) : wob_pkg::DIV_W'(r_pmul);
            r_neg <= r_pmul[57];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, hop_eff}) begin
                r_rem <= rem_sh - {1'b0, hop_eff};
                r_quo <= {r_quo[wob_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[wob_pkg::DIV_W-2:0], 1'b0};
            end
        end
        if (i_cmd.st_damp) begin
            r_damp <= wob_pkg::AMP_W'(quo_s);
        end
        if (i_cmd.st_dinc) begin
            r_dinc <= wob_pkg::PH_W'(quo_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= '0;
        end else if (i_cmd.ph_wr) begin
            r_pv[r_in.osc_index] <= 1'b1;
        end
    end

    wob_ram #(.W(AW), .D(wob_pkg::MAX_OSC + 1)) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ph_wr),
        .i_waddr (r_in.osc_index),
        .i_wdata (r_phase[wob_pkg::PH_W-1:32]),
        .i_raddr (r_in.osc_index),
        .o_rdata (ph_rdata)
    );

    // sample pipeline: lookup, slope multiply, interpolate, gain multiply, accumulate
    assign dy   = 17'(r1_y2) - 17'(r1_y1);
    assign ysum = 18'(r2_y1) + 18'(r2_d >>> 16);
    assign acc  = 34'($signed(buf_rdata)) + (r4_p >>> 15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_cmd.smp;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_y1 <= wob_pkg::sine_at(r_phase[wob_pkg::PH_W-1:32]);
        r1_y2 <= wob_pkg::sine_at(r_phase[wob_pkg::PH_W-1:32] + 1'b1);
        r1_f  <= r_phase[31:16];
        r1_ah <= r_amp[32:16];
        r1_a  <= i_cmd.cnt[wob_pkg::BUF_AW-1:0];
        r2_d  <= dy * $signed({1'b0, r1_f});
        r2_y1 <= r1_y1;
        r2_ah <= r1_ah;
        r2_a  <= r1_a;
        r3_y  <= ysum[16:0];
        r3_ah <= r2_ah;
        r3_a  <= r2_a;
        r4_p  <= r3_ah * r3_y;
        r4_a  <= r3_a;
    end

    assign buf_raddr = r3_v ? r3_a : r_dptr;
    assign buf_we    = i_cmd.clr_we | i_cmd.dr_wr | r4_v;
    assign buf_wdata = r4_v ? sat32(acc) : 32'd0;

    always_comb begin
        if (i_cmd.clr_we) begin
            buf_waddr = i_cmd.cnt[wob_pkg::BUF_AW-1:0];
        end else if (i_cmd.dr_wr) begin
            buf_waddr = r_dptr;
        end else begin
            buf_waddr = r4_a;
        end
    end

    wob_ram #(.W(32), .D(wob_pkg::HOP_MAX)) u_buf_ram (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wdata),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    assign dsum = 34'(r_in.prior_sample) + 34'($signed(buf_rdata));
    assign last = ({1'b0, r_dptr} + 1'b1) >= hop_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dptr <= '0;
            r_stb  <= 1'b0;
        end else begin
            r_stb <= i_cmd.dr_wr;
            if (i_cmd.dr_wr) begin
                r_dptr <= last ? '0 : r_dptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dr_wr) begin
            r_out.out_sample  <= sat32(dsum);
            r_out.last_sample <= last;
        end
    end

    assign o_strobe = r_stb;
    assign o_result = r_out;
endmodule

// ===== rtl/core/wavetable_oscillator_bank.sv =====
// Top level of the wavetable oscillator bank: controller plus datapath.
// Drain transfer: DR_RD, then DR_WR (strobe registered from it), then IDLE again.
// Oscillator transfer: two 57-step divisions, then one sample per cycle through a
// 4-stage pipeline into the synthesis buffer RAM.
// Idle or out-of-range oscillator: back to idle after the phase read. Results cannot be stalled.
// Reset: synchronous; busy while the synthesis buffer is cleared.
`timescale 1ns / 1ps
module wavetable_oscillator_bank (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  wob_pkg::t_in  i_item,
    output logic          o_strobe,
    output wob_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic          i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);
    wob_pkg::t_cmd  cmd;
    wob_pkg::t_stat stat;

    wob_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_item.cmd),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    wob_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );
endmodule
